// ----- rtl/core/desrf_pkg.sv -----
package desrf_pkg;

    localparam int HALF_W  = 32;
    localparam int KEY_W   = 48;
    localparam int GROUPS  = 8;
    localparam int SIX_W   = 6;
    localparam int NIB_W   = 4;

    typedef logic [HALF_W-1:0] t_half;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [SIX_W-1:0]  t_six;
    typedef logic [NIB_W-1:0]  t_nib;
    typedef logic [2:0]        t_box;

    localparam logic [5:0] E_TAB [KEY_W] = '{
        32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9,
        8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
        16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
        24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1
    };

    localparam logic [5:0] P_TAB [HALF_W] = '{
        16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
        2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
    };

    localparam logic [3:0] SBOX_TAB [GROUPS][64] = '{
        '{14, 4, 13, 1, 2, 15, 11, 8, 3, 10, 6, 12, 5, 9, 0, 7,
          0, 15, 7, 4, 14, 2, 13, 1, 10, 6, 12, 11, 9, 5, 3, 8,
          4, 1, 14, 8, 13, 6, 2, 11, 15, 12, 9, 7, 3, 10, 5, 0,
          15, 12, 8, 2, 4, 9, 1, 7, 5, 11, 3, 14, 10, 0, 6, 13},
        '{15, 1, 8, 14, 6, 11, 3, 4, 9, 7, 2, 13, 12, 0, 5, 10,
          3, 13, 4, 7, 15, 2, 8, 14, 12, 0, 1, 10, 6, 9, 11, 5,
          0, 14, 7, 11, 10, 4, 13, 1, 5, 8, 12, 6, 9, 3, 2, 15,
          13, 8, 10, 1, 3, 15, 4, 2, 11, 6, 7, 12, 0, 5, 14, 9},
        '{10, 0, 9, 14, 6, 3, 15, 5, 1, 13, 12, 7, 11, 4, 2, 8,
          13, 7, 0, 9, 3, 4, 6, 10, 2, 8, 5, 14, 12, 11, 15, 1,
          13, 6, 4, 9, 8, 15, 3, 0, 11, 1, 2, 12, 5, 10, 14, 7,
          1, 10, 13, 0, 6, 9, 8, 7, 4, 15, 14, 3, 11, 5, 2, 12},
        '{7, 13, 14, 3, 0, 6, 9, 10, 1, 2, 8, 5, 11, 12, 4, 15,
          13, 8, 11, 5, 6, 15, 0, 3, 4, 7, 2, 12, 1, 10, 14, 9,
          10, 6, 9, 0, 12, 11, 7, 13, 15, 1, 3, 14, 5, 2, 8, 4,
          3, 15, 0, 6, 10, 1, 13, 8, 9, 4, 5, 11, 12, 7, 2, 14},
        '{2, 12, 4, 1, 7, 10, 11, 6, 8, 5, 3, 15, 13, 0, 14, 9,
          14, 11, 2, 12, 4, 7, 13, 1, 5, 0, 15, 10, 3, 9, 8, 6,
          4, 2, 1, 11, 10, 13, 7, 8, 15, 9, 12, 5, 6, 3, 0, 14,
          11, 8, 12, 7, 1, 14, 2, 13, 6, 15, 0, 9, 10, 4, 5, 3},
        '{12, 1, 10, 15, 9, 2, 6, 8, 0, 13, 3, 4, 14, 7, 5, 11,
          10, 15, 4, 2, 7, 12, 9, 5, 6, 1, 13, 14, 0, 11, 3, 8,
          9, 14, 15, 5, 2, 8, 12, 3, 7, 0, 4, 10, 1, 13, 11, 6,
          4, 3, 2, 12, 9, 5, 15, 10, 11, 14, 1, 7, 6, 0, 8, 13},
        '{4, 11, 2, 14, 15, 0, 8, 13, 3, 12, 9, 7, 5, 10, 6, 1,
          13, 0, 11, 7, 4, 9, 1, 10, 14, 3, 5, 12, 2, 15, 8, 6,
          1, 4, 11, 13, 12, 3, 7, 14, 10, 15, 6, 8, 0, 5, 9, 2,
          6, 11, 13, 8, 1, 4, 10, 7, 9, 5, 0, 15, 14, 2, 3, 12},
        '{13, 2, 8, 4, 6, 15, 11, 1, 10, 9, 3, 14, 5, 0, 12, 7,
          1, 15, 13, 8, 10, 3, 7, 4, 12, 5, 6, 11, 0, 14, 9, 2,
          7, 11, 4, 1, 9, 12, 14, 2, 0, 6, 10, 13, 15, 3, 5, 8,
          2, 1, 14, 7, 4, 10, 8, 13, 15, 12, 9, 0, 3, 5, 6, 11}
    };

    // Bits are numbered from 1 at the most significant end, as in the standard.
    function automatic t_key expand(input t_half r);
        t_key e;
        for (int i = 0; i < KEY_W; i++) begin
            e[KEY_W-1-i] = r[5'(HALF_W - int'(E_TAB[i]))];
        end
        return e;
    endfunction

    function automatic t_half permute(input t_half s);
        t_half p;
        for (int i = 0; i < HALF_W; i++) begin
            p[HALF_W-1-i] = s[5'(HALF_W - int'(P_TAB[i]))];
        end
        return p;
    endfunction

endpackage

// ----- rtl/core/desrf_sbox.sv -----
module desrf_sbox (
    input  desrf_pkg::t_box i_box,
    input  desrf_pkg::t_six i_six,
    output desrf_pkg::t_nib o_nib
);
    import desrf_pkg::*;

    logic [5:0] w_addr;

    // The row is formed from the outer bits and the column from the inner four.
    assign w_addr = {i_six[5], i_six[0], i_six[4:1]};
    assign o_nib  = SBOX_TAB[i_box][w_addr];

endmodule

// ----- rtl/core/desrf_fcore.sv -----
module desrf_fcore (
    input  desrf_pkg::t_half i_half_block,
    input  desrf_pkg::t_key  i_round_key,
    output desrf_pkg::t_half o_f_result
);
    import desrf_pkg::*;

    t_key  w_mixed;
    t_half w_subst;

    assign w_mixed = expand(i_half_block) ^ i_round_key;

    for (genvar g = 0; g < GROUPS; g++) begin : g_box
        desrf_sbox u_sbox (
            .i_box (3'(g)),
            .i_six (w_mixed[KEY_W-1-SIX_W*g -: SIX_W]),
            .o_nib (w_subst[HALF_W-1-NIB_W*g -: NIB_W])
        );
    end

    assign o_f_result = permute(w_subst);

endmodule

// ----- rtl/core/des_round_function.sv -----
// DES round function f: P(S(E(R) xor K)).
// A request is captured in the input registers, then its result in the result register.
// Throughput: one request per cycle while the output is not stalled, set by the input
// and result registers with the whole f computation between them.
// Reset: synchronous, active low; clears both valid flags and holds input stalled.
module des_round_function (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  desrf_pkg::t_half i_half_block,
    input  desrf_pkg::t_key  i_round_key,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output desrf_pkg::t_half o_f_result
);
    import desrf_pkg::*;

    logic  r_s1_valid;
    t_half r_half;
    t_key  r_key;
    logic  r_out_valid;
    t_half r_f_result;
    t_half w_f;
    logic  w_s2_ready;
    logic  w_s1_ready;

    assign w_s2_ready = !r_out_valid || !i_out_stall;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_in_stall = !i_rst_n || !w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_in_valid) begin
            r_half <= i_half_block;
            r_key  <= i_round_key;
        end
    end

    desrf_fcore u_fcore (
        .i_half_block (r_half),
        .i_round_key  (r_key),
        .o_f_result   (w_f)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_valid) begin
            r_f_result <= w_f;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_f_result  = r_f_result;

`ifndef SYNTHESIS
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled while the pipeline has room");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s1_valid)
        else $error("accepted request was not captured");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_s2_ready) |=> (o_out_valid && o_f_result == $past(w_f)))
        else $error("result register did not take the computed value");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_ready) |=> r_s1_valid && $stable(r_half) && $stable(r_key))
        else $error("held request was lost or altered");
`endif

endmodule
